### src/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg: shared types and constants for the sliding window max filter
// Sample type, window register width and the default window store depth.
// ----------------------------------------------------------------------------
`default_nettype none

package swmf_pkg;

	// Payload widths fixed by the stream format
	localparam int SAMPLE_W = 32;
	localparam int WLEN_W   = 7;

	// Default depth of the window store (cells in the chain)
	localparam int WINDOW_DEPTH_DEF = 64;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [WLEN_W-1:0]   wlen_t;

	// Most negative sample, the neutral value for a running maximum
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage : swmf_pkg

`default_nettype wire

### src/swmf_in_if.sv
// ----------------------------------------------------------------------------
// swmf_in_if: sample stream channel
// Valid/ready channel carrying one sample and its end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface swmf_in_if;
	import swmf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;
	logic    frame_end;

	modport source (output valid, output sample, output frame_end, input ready);
	modport sink   (input valid, input sample, input frame_end, output ready);

endinterface : swmf_in_if

`default_nettype wire

### src/swmf_out_if.sv
// ----------------------------------------------------------------------------
// swmf_out_if: window maximum result channel
// Valid/ready channel carrying one window maximum and its last-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface swmf_out_if;
	import swmf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t window_max;
	logic    last_of_frame;

	modport source (output valid, output window_max, output last_of_frame, input ready);
	modport sink   (input valid, input window_max, input last_of_frame, output ready);

endinterface : swmf_out_if

`default_nettype wire

### src/swmf_cell.sv
// ----------------------------------------------------------------------------
// swmf_cell: one cell of the window chain
// Holds one sample of the shift line and folds it into the running maximum
// that moves one cell further down the chain every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_cell (
	input  wire                     clk,
	input  wire                     shift_en,
	input  wire swmf_pkg::sample_t  shift_in,
	output swmf_pkg::sample_t       shift_out,
	input  wire swmf_pkg::sample_t  max_in,
	output swmf_pkg::sample_t       max_out
);
	import swmf_pkg::*;

	sample_t sample_q;
	sample_t max_q;

	// Sample shift line: newest sample enters at cell 0
	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= shift_in;
		end
	end

	// Running maximum of this cell and all cells upstream
	always_ff @(posedge clk) begin
		max_q <= (sample_q > max_in) ? sample_q : max_in;
	end

	assign shift_out = sample_q;
	assign max_out   = max_q;

endmodule : swmf_cell

`default_nettype wire

### src/swmf_chain.sv
// ----------------------------------------------------------------------------
// swmf_chain: row of window cells with the prefix maximum tap
// Cell j holds the j-th most recent sample; once the samples stop moving, its
// maximum output settles to the maximum of cells 0..j.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_chain #(
	parameter int WINDOW_DEPTH = swmf_pkg::WINDOW_DEPTH_DEF,
	parameter int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
	input  wire                     clk,
	input  wire                     shift_en,
	input  wire swmf_pkg::sample_t  sample_in,
	input  wire [IDX_W-1:0]         tap_sel,
	output swmf_pkg::sample_t       tap_max
);
	import swmf_pkg::*;

	sample_t shift_w [WINDOW_DEPTH+1];
	sample_t max_w   [WINDOW_DEPTH+1];

	assign shift_w[0] = sample_in;
	assign max_w[0]   = SAMPLE_MIN;

	// Row of identical cells, each handing sample and maximum to the next
	for (genvar j = 0; j < WINDOW_DEPTH; j++) begin : g_cell
		swmf_cell u_cell (
			.clk       (clk),
			.shift_en  (shift_en),
			.shift_in  (shift_w[j]),
			.shift_out (shift_w[j+1]),
			.max_in    (max_w[j]),
			.max_out   (max_w[j+1])
		);
	end

	// Tap the prefix maximum at the end of the current window
	always_comb begin
		tap_max = SAMPLE_MIN;
		for (int j = 0; j < WINDOW_DEPTH; j++) begin
			if (tap_sel == IDX_W'(j)) begin
				tap_max = max_w[j+1];
			end
		end
	end

endmodule : swmf_chain

`default_nettype wire

### src/sliding_window_max_filter.sv
// ----------------------------------------------------------------------------
// sliding_window_max_filter: framed sliding window maximum
// Emits the maximum of the last window_length samples of each frame.
// ----------------------------------------------------------------------------
// The samples channel accepts one sample per transaction. A sample that does
// not complete a full window in its frame yields nothing; one that does yields
// one result. The running maximum walks one cell of the window chain per cycle
// across the window length clamped to 1..WINDOW_DEPTH, then the result is
// loaded into the output register once it is free. The next sample is accepted
// while that result waits on the results channel. A frame end clears the fill
// count; a window length of zero acts as one. window_length resets to 1; the
// user must write it only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_filter #(
	parameter int WINDOW_DEPTH = swmf_pkg::WINDOW_DEPTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wr_en,
	input  wire swmf_pkg::wlen_t  cfg_wr_data,
	swmf_in_if.sink               samples,
	swmf_out_if.source            results
);
	import swmf_pkg::*;

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int KW    = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	wlen_t            wlen_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] sel_q;
	logic             end_q;
	logic             out_valid_q;
	sample_t          window_max_q;
	logic             last_q;

	logic [KW-1:0]    k_wide;
	logic [CNT_W-1:0] k_eff;
	logic [CNT_W-1:0] fill_next;
	logic             accept;
	logic             produce;
	logic             load_out;
	sample_t          tap_max;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_W'(1);
		end else if (cfg_wr_en) begin
			wlen_q <= cfg_wr_data;
		end
	end

	// Effective window: zero acts as one, saturate at the store depth
	always_comb begin
		k_wide = KW'(wlen_q);
		if (k_wide == '0) begin
			k_wide = KW'(1);
		end else if (k_wide > KW'(WINDOW_DEPTH)) begin
			k_wide = KW'(WINDOW_DEPTH);
		end
		k_eff = CNT_W'(k_wide);
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign fill_next     = (fill_q < CNT_W'(WINDOW_DEPTH)) ? fill_q + CNT_W'(1) : fill_q;
	assign produce       = (fill_next >= k_eff);
	assign load_out      = (state_q == ST_RUN) && (cnt_q == '0) &&
	                       (!out_valid_q || results.ready);

	swmf_chain #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.IDX_W        (IDX_W)
	) u_chain (
		.clk       (clk),
		.shift_en  (accept),
		.sample_in (samples.sample),
		.tap_sel   (sel_q),
		.tap_max   (tap_max)
	);

	// Sequencer: wait for the maximum to reach the window end cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q <= samples.frame_end ? '0 : fill_next;
						if (produce) begin
							state_q <= ST_RUN;
							cnt_q   <= k_eff;
						end
					end
				end
				ST_RUN: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Per-transaction payload captured at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q <= IDX_W'(k_eff - CNT_W'(1));
			end_q <= samples.frame_end;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			window_max_q <= tap_max;
			last_q       <= end_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.window_max    = window_max_q;
	assign results.last_of_frame = last_q;

endmodule : sliding_window_max_filter

`default_nettype wire

### tb/sliding_window_max_filter_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_max_filter_tb: self-checking bench for the window max filter
// Drives framed samples and tracks the window maximum of each one in the bench.
// Every result transaction is checked against the oldest pending maximum. The
// window length is changed between phases, and the phases vary idling on both
// channels. One long output hold-off makes the block stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_filter_tb;
	import swmf_pkg::*;

	localparam int STORE_DEPTH = WINDOW_DEPTH_DEF;
	// Cycles to let pass after the last result, covering a full window walk
	localparam int SETTLE_CYCLES = STORE_DEPTH + 8;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct {
		sample_t window_max;
		logic    last_of_frame;
	} max_result_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_wr_en;
	wlen_t cfg_wr_data;

	swmf_in_if  samples_if ();
	swmf_out_if results_if ();

	sliding_window_max_filter #(
		.WINDOW_DEPTH(STORE_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.samples     (samples_if.sink),
		.results     (results_if.source)
	);

	// Bench copy of the filter state
	sample_t     ring_store [STORE_DEPTH];
	int unsigned held_count = 0;
	int unsigned ring_pos = 0;
	wlen_t       window_reg = wlen_t'(1);
	max_result_t pending_maxima [$];

	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#6000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Window length as the block applies it: 0 acts as 1, saturates at depth
	function automatic int unsigned eff_window();
		int unsigned k;
		k = window_reg;
		if (k == 0)
			k = 1;
		if (k > STORE_DEPTH)
			k = STORE_DEPTH;
		return k;
	endfunction

	// Update the bench state for one accepted sample, queue its maximum if any
	function automatic void track_window_max(sample_t s, logic fe);
		int unsigned k;
		int unsigned idx;
		sample_t     best;
		max_result_t r;
		k = eff_window();
		ring_store[ring_pos] = s;
		ring_pos = (ring_pos + 1) % STORE_DEPTH;
		if (held_count < STORE_DEPTH)
			held_count++;
		if (held_count >= k) begin
			best = s;
			for (int unsigned i = 1; i < k; i++) begin
				idx = (ring_pos + 2 * STORE_DEPTH - 1 - i) % STORE_DEPTH;
				if (ring_store[idx] > best)
					best = ring_store[idx];
			end
			r.window_max = best;
			r.last_of_frame = fe;
			pending_maxima = {pending_maxima, r};
		end
		if (fe) begin
			held_count = 0;
			ring_pos = 0;
		end
	endfunction

	// Result receiver: random stalls plus requested long hold-offs
	initial begin
		int holds_seen;
		int hold_left;
		holds_seen = 0;
		hold_left = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		max_result_t exp_r;
		if (arst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			if (pending_maxima.size() == 0) begin
				$error("result transaction with nothing pending: window_max %0d",
					results_if.window_max);
				fail_count++;
			end else begin
				exp_r = pending_maxima.pop_front();
				if (results_if.window_max !== exp_r.window_max) begin
					$error("window_max expected %0d actual %0d",
						exp_r.window_max, results_if.window_max);
					fail_count++;
				end
				if (results_if.last_of_frame !== exp_r.last_of_frame) begin
					$error("last_of_frame expected %0b actual %0b",
						exp_r.last_of_frame, results_if.last_of_frame);
					fail_count++;
				end
			end
		end
	end

	// Offer one sample, return at the edge where the transaction completes
	task automatic send_sample(input sample_t s, input logic fe);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample <= s;
		samples_if.frame_end <= fe;
		@(posedge clk);
		while (samples_if.ready !== 1'b1)
			@(posedge clk);
		track_window_max(s, fe);
	endtask

	// Drain, let the window walk finish, then write the window length
	task automatic set_window(input wlen_t v);
		samples_if.valid <= 1'b0;
		while (pending_maxima.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		window_reg = v;
		cfg_wr_en <= 1'b0;
	endtask

	// Extremes, near zero values and plain random bits
	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MIN;
			1: return sample_t'(32'h7fff_ffff);
			2: return sample_t'($signed($urandom_range(16)) - 8);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Frame lengths mostly around the window, some short, some past the store
	function automatic int pick_frame_len();
		int k;
		k = eff_window();
		case ($urandom_range(9))
			0: return (k > 1) ? $urandom_range(k - 1, 1) : 1;
			1: return $urandom_range(STORE_DEPTH + 1, 2 * STORE_DEPTH + 12);
			2: return $urandom_range(3, 1);
			default: return k + $urandom_range(24);
		endcase
	endfunction

	// Random framed traffic; a few frames have random frame-end flags
	task automatic run_random(input int n_items, input int idle_pct, input int stall_pct);
		int sent;
		int len;
		bit noisy;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			len = pick_frame_len();
			noisy = ($urandom_range(11) == 0);
			for (int i = 0; i < len; i++)
				send_sample(pick_sample(), noisy ? 1'($urandom) : (i == len - 1));
			sent += len;
		end
	endtask

	// Reset window of one: every sample is its own maximum
	task automatic test_default_window();
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(sample_t'(32'h7fff_ffff), 1'b0);
		send_sample(sample_t'(0), 1'b0);
		send_sample(sample_t'(-1), 1'b0);
		send_sample(sample_t'(1), 1'b1);
	endtask

	// Frame end before the window fills, then a frame that fills it
	task automatic test_short_frames();
		set_window(wlen_t'(4));
		send_sample(sample_t'(7), 1'b0);
		send_sample(sample_t'(8), 1'b0);
		send_sample(sample_t'(9), 1'b1);
		send_sample(sample_t'(-5), 1'b0);
		send_sample(sample_t'(32'h7fff_ffff), 1'b0);
		send_sample(sample_t'(-1), 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(sample_t'(3), 1'b0);
		send_sample(sample_t'(2), 1'b1);
	endtask

	// A zero window acts as a window of one
	task automatic test_zero_window();
		set_window(wlen_t'(0));
		send_sample(sample_t'(-100), 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(sample_t'(42), 1'b1);
	endtask

	// Window length changed while a frame is open
	task automatic test_window_change_in_frame();
		set_window(wlen_t'(2));
		send_sample(sample_t'(10), 1'b0);
		send_sample(sample_t'(-20), 1'b0);
		set_window(wlen_t'(5));
		send_sample(sample_t'(-30), 1'b0);
		send_sample(sample_t'(-40), 1'b0);
		send_sample(sample_t'(-50), 1'b1);
	endtask

	// Random traffic over several windows and idling patterns
	task automatic test_random_traffic();
		set_window(wlen_t'($urandom_range(8, 1)));
		run_random(400, 0, 0);
		set_window(wlen_t'(STORE_DEPTH));
		run_random(250, 50, 0);
		set_window(wlen_t'(127));
		run_random(200, 0, 50);
		set_window(wlen_t'(0));
		run_random(300, 23, 23);
		for (int seg = 0; seg < 7; seg++) begin
			if ($urandom_range(3) == 0)
				set_window(wlen_t'($urandom_range(127)));
			else
				set_window(wlen_t'($urandom_range(12, 1)));
			case (seg % 4)
				0: run_random(100, 0, 0);
				1: run_random(100, 50, 0);
				2: run_random(100, 0, 50);
				default: run_random(100, 23, 23);
			endcase
		end
	endtask

	// Long receiver hold-off while samples keep coming, input must stall
	task automatic test_output_backpressure();
		set_window(wlen_t'(1));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests++;
		for (int i = 0; i < 100; i++)
			send_sample(pick_sample(), ($urandom_range(15) == 0) || (i == 99));
	endtask

	// Sequence of tests and the final verdict
	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= wlen_t'(1);
		samples_if.valid <= 1'b0;
		samples_if.sample <= sample_t'(0);
		samples_if.frame_end <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_default_window();
		test_short_frames();
		test_zero_window();
		test_window_change_in_frame();
		test_output_backpressure();
		test_random_traffic();

		samples_if.valid <= 1'b0;
		recv_stall_pct = 0;
		while (pending_maxima.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_maxima.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule : sliding_window_max_filter_tb

`default_nettype wire
